FILE: design/htqp_pkg.sv
// Shared types, constants and helpers of the quadratic-probe hash table.
package htqp_pkg;

   // Slot count of the table; it must be a power of two between 2 and 4096.
   localparam int TBL_SLOTS  = 16;
   localparam int SLOT_BITS  = $clog2(TBL_SLOTS);
   localparam int KEY_BITS   = 31;
   localparam int VALUE_BITS = 32;
   localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;
   localparam int SLOT_FIELD_BITS = 4;

   typedef enum logic [2:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_UPDATED   = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_FOUND     = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_SEARCH = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                  req_type;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [2:0]                 status;
      logic [VALUE_BITS-1:0]      found_value;
      logic [SLOT_FIELD_BITS-1:0] slot;
   } rsp_word_type;

   // The reported slot field carries the low bits of the slot number.
   function automatic logic [SLOT_FIELD_BITS-1:0] slot_field(
      input logic [SLOT_BITS-1:0] idx
   );
      logic [SLOT_BITS+SLOT_FIELD_BITS-1:0] wide;
      wide = (SLOT_BITS + SLOT_FIELD_BITS)'(idx);
      return wide[SLOT_FIELD_BITS-1:0];
   endfunction

endpackage

FILE: design/htqp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module htqp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/hash_table_quadratic_probe.sv
// Top level of the open-addressing key/value table with quadratic probing.
//
// Each request word either inserts (or updates) a key with a 32-bit value, or
// searches for a key, and yields exactly one response word. The home slot is
// the low bits of the key, and probe i visits (home + i*i) modulo the slot
// count. A walk stops at an empty slot, at a matching key, or when it comes
// back to the home slot, which reports the table as full or the key as not
// found. Keys and values live in one synchronous RAM with a registered read;
// the occupied flags are flip-flops cleared by reset, so the table is usable
// as soon as reset ends. The block works on one request at a time: the
// request is taken, and its slots are then probed one after another,
// because the single RAM read port delivers one stored entry per cycle.
// The walk comes back home at the first i for which i*i is a multiple of the
// slot count; with 16 slots that is i = 4, so a walk probes at most 4 slots.
// Its response is registered at the end of the last probe. The response
// register lets the next request in while an earlier response is still held
// by a stalled consumer; a walk that finishes while that register is still
// full waits in place until it drains.
module hash_table_quadratic_probe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  htqp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output htqp_pkg::rsp_word_type rsp_word
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PROBE = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Request held for the length of the walk.
   logic                              is_search_ff;
   logic [htqp_pkg::KEY_BITS-1:0]     key_ff;
   logic [htqp_pkg::VALUE_BITS-1:0]   value_ff;
   logic [htqp_pkg::SLOT_BITS-1:0]    home_ff;

   // Probe position. sq_ff holds i*i and odd_ff holds 2i+1 for the next
   // probe, both modulo the slot count, so the square is built by adds.
   logic [htqp_pkg::SLOT_BITS-1:0]    idx_ff, idx_in;
   logic [htqp_pkg::SLOT_BITS-1:0]    sq_ff, sq_in;
   logic [htqp_pkg::SLOT_BITS-1:0]    odd_ff, odd_in;

   logic [htqp_pkg::TBL_SLOTS-1:0]    used_ff, used_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   htqp_pkg::rsp_word_type            rsp_word_ff, rsp_word_in;

   // RAM ports.
   logic                              ram_wr_en;
   logic [htqp_pkg::SLOT_BITS-1:0]    ram_rd_addr;
   logic [htqp_pkg::ENTRY_BITS-1:0]   ram_wr_data;
   logic [htqp_pkg::ENTRY_BITS-1:0]   ram_rd_data;

   logic                              accept;
   logic                              out_free;
   logic                              slot_used;
   logic                              key_match;
   logic [htqp_pkg::SLOT_BITS-1:0]    next_idx;
   logic                              wrapped;
   logic                              cont;
   logic                              finish;
   logic [htqp_pkg::KEY_BITS-1:0]     rd_key;
   logic [htqp_pkg::VALUE_BITS-1:0]   rd_value;

   htqp_ram #(
      .WIDTH (htqp_pkg::ENTRY_BITS),
      .DEPTH (htqp_pkg::TBL_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_key   = ram_rd_data[htqp_pkg::ENTRY_BITS-1 -: htqp_pkg::KEY_BITS];
   assign rd_value = ram_rd_data[htqp_pkg::VALUE_BITS-1:0];
   assign ram_wr_data = {key_ff, value_ff};

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Evaluation of the entry read in the previous cycle.
   assign slot_used = used_ff[idx_ff];
   assign key_match = (rd_key == key_ff);
   assign next_idx  = home_ff + sq_ff;
   assign wrapped   = (next_idx == home_ff);
   assign cont      = (state_ff == ST_PROBE) && slot_used && !key_match && !wrapped;
   assign finish    = (state_ff == ST_PROBE) && !cont && out_free;

   // A continuing walk reads the next slot at once; a walk that waits for
   // the response register keeps reading the same slot so its data holds.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         ram_rd_addr = req_word.key[htqp_pkg::SLOT_BITS-1:0];
      end else if (cont) begin
         ram_rd_addr = next_idx;
      end else begin
         ram_rd_addr = idx_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      sq_in        = sq_ff;
      odd_in       = odd_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      ram_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PROBE;
               idx_in   = req_word.key[htqp_pkg::SLOT_BITS-1:0];
               sq_in    = htqp_pkg::SLOT_BITS'(1);
               odd_in   = htqp_pkg::SLOT_BITS'(3);
            end
         end
         ST_PROBE: begin
            if (cont) begin
               idx_in = next_idx;
               sq_in  = sq_ff + odd_ff;
               odd_in = odd_ff + htqp_pkg::SLOT_BITS'(2);
            end else if (finish) begin
               state_in                = ST_IDLE;
               rsp_valid_in            = 1'b1;
               rsp_word_in.found_value = '0;
               rsp_word_in.slot        = '0;
               if (slot_used && key_match) begin
                  rsp_word_in.slot = htqp_pkg::slot_field(idx_ff);
                  if (is_search_ff == htqp_pkg::REQ_SEARCH) begin
                     rsp_word_in.status      = htqp_pkg::STATUS_FOUND;
                     rsp_word_in.found_value = rd_value;
                  end else begin
                     rsp_word_in.status = htqp_pkg::STATUS_UPDATED;
                     ram_wr_en          = 1'b1;
                  end
               end else if (slot_used) begin
                  // The walk came back to the home slot.
                  if (is_search_ff == htqp_pkg::REQ_SEARCH) begin
                     rsp_word_in.status = htqp_pkg::STATUS_NOT_FOUND;
                  end else begin
                     rsp_word_in.status = htqp_pkg::STATUS_FULL;
                  end
               end else begin
                  if (is_search_ff == htqp_pkg::REQ_SEARCH) begin
                     rsp_word_in.status = htqp_pkg::STATUS_NOT_FOUND;
                  end else begin
                     rsp_word_in.status = htqp_pkg::STATUS_INSERTED;
                     rsp_word_in.slot   = htqp_pkg::slot_field(idx_ff);
                     ram_wr_en          = 1'b1;
                     used_in[idx_ff]    = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         is_search_ff <= req_word.req_type;
         key_ff       <= req_word.key;
         value_ff     <= req_word.value;
         home_ff      <= req_word.key[htqp_pkg::SLOT_BITS-1:0];
      end
      idx_ff      <= idx_in;
      sq_ff       <= sq_in;
      odd_ff      <= odd_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
